>>> hw/rtl/spmv_pkg.sv
// spmv_pkg: shared types, widths, action codes and the sigmoid table
// for the CSR sparse matrix-vector block. No dependencies.
`timescale 1ns / 1ps

package spmv_pkg;

    // Field widths
    localparam int ROW_COUNT_W = 6;
    localparam int SLOT_W      = 8;
    localparam int COL_W       = 5;
    localparam int WEIGHT_W    = 16;
    localparam int PTR_W       = 9;
    localparam int ELEM_W      = 16;
    localparam int ROW_W       = 5;
    localparam int ACT_W       = 16;
    localparam int ACTION_W    = 2;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;
    localparam int IDX_W       = 8;
    localparam int SIG_DEPTH   = 256;

    // Stream word widths (fields packed, padded to whole bytes)
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    // Size defaults and limits
    localparam int MAX_ROWS_DEF     = 32;
    localparam int VECTOR_DEPTH_DEF = 32;
    localparam int MAX_NONZEROS_DEF = 256;
    localparam int RESULT_LIMIT     = 32;

    localparam logic [ROW_COUNT_W-1:0] ROW_COUNT_RST = 6'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NZ  = 2'd0,
        ACT_PTR = 2'd1,
        ACT_VEC = 2'd2,
        ACT_RUN = 2'd3
    } action_t;

    // One entry of the nonzero store
    typedef struct packed {
        logic [COL_W-1:0]           col;
        logic signed [WEIGHT_W-1:0] weight;
    } nz_entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // an input word is taken this cycle
        logic ptr_rd;    // read the row pointer store
        logic ld_start;  // row start from pointer read data
        logic ld_end;    // row end from pointer read data, clear accumulator
        logic next_row;  // next row starts where the last one ended
        logic mac_run;   // walk the nonzeros of the row
        logic idx_calc;  // clamp the sum and form the table index
        logic out_load;  // load the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic mac_done;  // all terms issued and the pipe has drained
    } stat_t;

    typedef logic [SIG_DEPTH-1:0][ACT_W-1:0] sig_table_t;

    // Shift-subtract unsigned division, used only at elaboration
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        int          b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem      = rem - den;
                quo[b]   = 1'b1;
            end
        end
        return quo;
    endfunction

    // Logistic table: entry i is sigmoid(-8 + i/16) in Q0.16
    function automatic sig_table_t build_sig_table();
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] n;
        logic [63:0] step;
        logic [63:0] d;
        logic [63:0] v;
        logic [63:0] pw [129];
        logic        neg;
        int          k;
        int          i;
        sig_table_t  tbl;
        term = 64'd1 << 60;
        sum  = '0;
        n    = 64'd1;
        neg  = 1'b0;
        // e^(-1/16) by its Taylor series in Q60
        for (k = 0; k < 32; k++)
        begin
            if (term != 64'd0)
            begin
                if (neg)
                    sum = sum - term;
                else
                    sum = sum + term;
                term = udiv64(term, 64'd16 * n);
                n    = n + 64'd1;
                neg  = !neg;
            end
        end
        step  = (sum + (64'd1 << 28)) >> 29;
        pw[0] = 64'd1 << 31;
        for (k = 1; k <= 128; k++)
            pw[k] = (pw[k-1] * step + (64'd1 << 30)) >> 31;
        for (i = 0; i < SIG_DEPTH; i++)
        begin
            if (i >= 128)
            begin
                d = (64'd1 << 31) + pw[i-128];
                v = udiv64((64'd1 << 47) + (d >> 1), d);
            end
            else
            begin
                d = (64'd1 << 31) + pw[128-i];
                v = udiv64((pw[128-i] << 16) + (d >> 1), d);
            end
            if (v > 64'd65535)
                v = 64'd65535;
            tbl[i] = v[ACT_W-1:0];
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

>>> hw/rtl/spmv_ctrl.sv
// spmv_ctrl: controller state machine for the CSR sparse matrix-vector block.
// Holds the row count register and the output valid flag; drives cmd_t.
// Depends on spmv_pkg.
`timescale 1ns / 1ps

module spmv_ctrl #(
    parameter int MAX_ROWS = spmv_pkg::MAX_ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  spmv_pkg::action_t                s_action,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [spmv_pkg::ROW_COUNT_W-1:0] cfg_data,
    output spmv_pkg::cmd_t                   cmd,
    output logic [$clog2(MAX_ROWS+1)-1:0]    ptr_addr,
    output logic [spmv_pkg::ROW_W-1:0]       out_row,
    output logic                             out_last,
    input  spmv_pkg::stat_t                  stat
);

    localparam int ROW_LIMIT = (MAX_ROWS < spmv_pkg::RESULT_LIMIT) ? MAX_ROWS
                                                                    : spmv_pkg::RESULT_LIMIT;
    localparam int RW   = $clog2(ROW_LIMIT + 1);
    localparam int PA_W = $clog2(MAX_ROWS + 1);
    localparam int RCW  = spmv_pkg::ROW_COUNT_W;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_START   = 8'b0000_0010,
        ST_LDSTART = 8'b0000_0100,
        ST_LDEND   = 8'b0000_1000,
        ST_MAC     = 8'b0001_0000,
        ST_IDX     = 8'b0010_0000,
        ST_EMIT    = 8'b0100_0000,
        ST_NEXT    = 8'b1000_0000
    } state_t;

    state_t         state_reg, state_next;
    logic [RW-1:0]  r_reg, r_next;
    logic [RCW-1:0] row_count_reg, row_count_next;
    logic           out_valid_reg, out_valid_next;

    logic [RCW-1:0] rows_eff;
    logic [RW:0]    r_inc;
    logic           in_take;

    // Rows per run, clamped to the supported limit
    assign rows_eff = (row_count_reg > RCW'(ROW_LIMIT)) ? RCW'(ROW_LIMIT) : row_count_reg;
    assign r_inc    = {1'b0, r_reg} + 1'b1;
    assign out_last = (RCW'(r_inc) == rows_eff);
    assign out_row  = spmv_pkg::ROW_W'(r_reg);
    assign ptr_addr = (state_reg == ST_START) ? '0 : PA_W'(r_inc);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_take   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign cfg_ready = 1'b1;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg;
        row_count_next = row_count_reg;
        cmd            = '0;
        cmd.load       = in_take;

        if (cfg_valid)
            row_count_next = cfg_data;

        if (m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (s_action == spmv_pkg::ACT_RUN) && (rows_eff != '0))
                begin
                    r_next     = '0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.ptr_rd = 1'b1;
                state_next = ST_LDSTART;
            end
            ST_LDSTART:
            begin
                cmd.ld_start = 1'b1;
                cmd.ptr_rd   = 1'b1;
                state_next   = ST_LDEND;
            end
            ST_LDEND:
            begin
                cmd.ld_end = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_run = 1'b1;
                if (stat.mac_done)
                    state_next = ST_IDX;
            end
            ST_IDX:
            begin
                cmd.idx_calc = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // wait until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    if (out_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        r_next     = RW'(r_inc);
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT:
            begin
                cmd.next_row = 1'b1;
                cmd.ptr_rd   = 1'b1;
                state_next   = ST_LDEND;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            row_count_reg <= spmv_pkg::ROW_COUNT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            row_count_reg <= row_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/spmv_datapath.sv
// spmv_datapath: stores, multiply-accumulate pipe, clamp and sigmoid lookup,
// and the output register. Driven by spmv_ctrl through cmd_t.
// Depends on spmv_pkg.
`timescale 1ns / 1ps

module spmv_datapath #(
    parameter int MAX_ROWS     = spmv_pkg::MAX_ROWS_DEF,
    parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF,
    parameter int MAX_NONZEROS = spmv_pkg::MAX_NONZEROS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  spmv_pkg::action_t                    action,
    input  logic [spmv_pkg::SLOT_W-1:0]          slot,
    input  logic [spmv_pkg::COL_W-1:0]           column_number,
    input  logic signed [spmv_pkg::WEIGHT_W-1:0] weight_value,
    input  logic [spmv_pkg::PTR_W-1:0]           pointer_value,
    input  logic signed [spmv_pkg::ELEM_W-1:0]   element_value,
    input  spmv_pkg::cmd_t                       cmd,
    input  logic [$clog2(MAX_ROWS+1)-1:0]        ptr_addr,
    input  logic [spmv_pkg::ROW_W-1:0]           out_row,
    input  logic                                 out_last,
    output spmv_pkg::stat_t                      stat,
    output logic [spmv_pkg::ROW_W-1:0]           row_number,
    output logic [spmv_pkg::ACT_W-1:0]           activation,
    output logic                                 last_row
);

    localparam int PA_W   = $clog2(MAX_ROWS + 1);
    localparam int NZ_AW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int VEC_AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int NZ_XW  = (NZ_AW > spmv_pkg::PTR_W) ? NZ_AW : spmv_pkg::PTR_W;
    localparam int NZ_SW  = (NZ_AW > spmv_pkg::SLOT_W) ? NZ_AW : spmv_pkg::SLOT_W;
    localparam int VEC_XW = (VEC_AW > spmv_pkg::COL_W) ? VEC_AW : spmv_pkg::COL_W;
    localparam int VEC_SW = (VEC_AW > spmv_pkg::SLOT_W) ? VEC_AW : spmv_pkg::SLOT_W;
    localparam int PW     = spmv_pkg::PTR_W;
    localparam int ACC_W  = spmv_pkg::ACC_W;
    localparam int PROD_W = spmv_pkg::PROD_W;

    // Stores
    spmv_pkg::nz_entry_t                nz_mem  [MAX_NONZEROS];
    logic [PW-1:0]                      ptr_mem [MAX_ROWS+1];
    logic signed [spmv_pkg::ELEM_W-1:0] vec_mem [VECTOR_DEPTH];

    logic [PW-1:0]                        ptr_q_reg;
    logic [PW-1:0]                        j_reg;
    logic [PW-1:0]                        end_reg;
    spmv_pkg::nz_entry_t                  nz_q_reg;
    logic signed [spmv_pkg::WEIGHT_W-1:0] w2_reg;
    logic signed [spmv_pkg::ELEM_W-1:0]   vec_q_reg;
    logic signed [PROD_W-1:0]             prod_reg;
    logic signed [ACC_W-1:0]              acc_reg;
    logic [spmv_pkg::IDX_W-1:0]           idx_reg;
    logic                                 v1_reg, v2_reg, v3_reg;

    logic [spmv_pkg::ROW_W-1:0]           row_out_reg;
    logic [spmv_pkg::ACT_W-1:0]           act_out_reg;
    logic                                 last_out_reg;

    logic [NZ_XW-1:0]    j_ext;
    logic [NZ_SW-1:0]    nz_slot_ext;
    logic [VEC_XW-1:0]   col_ext;
    logic [VEC_SW-1:0]   vec_slot_ext;
    logic                issue;
    logic                j_in_store;
    logic                col_in_store;
    logic [ACC_W-1:0]    prod_ext;
    logic                sum_low;
    logic                sum_high;
    logic [spmv_pkg::IDX_W-1:0] idx_calc;

    assign j_ext        = NZ_XW'(j_reg);
    assign nz_slot_ext  = NZ_SW'(slot);
    assign col_ext      = VEC_XW'(nz_q_reg.col);
    assign vec_slot_ext = VEC_SW'(slot);

    assign issue        = cmd.mac_run && (j_reg < end_reg);
    assign j_in_store   = (32'(j_reg) < MAX_NONZEROS);
    assign col_in_store = (32'(nz_q_reg.col) < VECTOR_DEPTH);
    assign stat.mac_done = !(j_reg < end_reg) && !v1_reg && !v2_reg && !v3_reg;

    // Store writes from load words
    always_ff @(posedge clk)
    begin
        if (cmd.load && (action == spmv_pkg::ACT_NZ) && (32'(slot) < MAX_NONZEROS))
            nz_mem[nz_slot_ext[NZ_AW-1:0]] <= '{col: column_number, weight: weight_value};
        if (cmd.load && (action == spmv_pkg::ACT_PTR) && (32'(slot) <= MAX_ROWS))
            ptr_mem[slot[PA_W-1:0]] <= pointer_value;
        if (cmd.load && (action == spmv_pkg::ACT_VEC) && (32'(slot) < VECTOR_DEPTH))
            vec_mem[vec_slot_ext[VEC_AW-1:0]] <= element_value;
    end

    // Row pointer read and nonzero walk
    always_ff @(posedge clk)
    begin
        if (cmd.ptr_rd)
            ptr_q_reg <= ptr_mem[ptr_addr];
        if (cmd.ld_end)
            end_reg <= ptr_q_reg;
        if (cmd.ld_start)
            j_reg <= ptr_q_reg;
        else if (cmd.next_row)
            j_reg <= end_reg;
        else if (issue)
            j_reg <= j_reg + 1'b1;
    end

    // MAC pipe: nonzero read, vector read, multiply, accumulate
    always_ff @(posedge clk)
    begin
        nz_q_reg  <= nz_mem[j_ext[NZ_AW-1:0]];
        vec_q_reg <= vec_mem[col_ext[VEC_AW-1:0]];
        w2_reg    <= nz_q_reg.weight;
        prod_reg  <= $signed({{(PROD_W-spmv_pkg::WEIGHT_W){w2_reg[spmv_pkg::WEIGHT_W-1]}},
                              w2_reg})
                   * $signed({{(PROD_W-spmv_pkg::ELEM_W){vec_q_reg[spmv_pkg::ELEM_W-1]}},
                              vec_q_reg});
        if (cmd.ld_end)
            acc_reg <= '0;
        else if (v3_reg)
            acc_reg <= acc_reg + $signed(prod_ext);
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Pipe valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue && j_in_store;
            v2_reg <= v1_reg && col_in_store;
            v3_reg <= v2_reg;
        end
    end

    // Clamp to [-8, 8) and form the table index
    assign sum_low  = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:27]);
    assign sum_high = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:27]);

    always_comb
    begin
        priority if (sum_low)
            idx_calc = '0;
        else if (sum_high)
            idx_calc = '1;
        else
            idx_calc = {~acc_reg[27], acc_reg[26:20]};
    end

    // Index and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.idx_calc)
            idx_reg <= idx_calc;
        if (cmd.out_load)
        begin
            act_out_reg  <= spmv_pkg::SIG_TABLE[idx_reg];
            row_out_reg  <= out_row;
            last_out_reg <= out_last;
        end
    end

    assign row_number = row_out_reg;
    assign activation = act_out_reg;
    assign last_row   = last_out_reg;

endmodule

>>> hw/rtl/csr_spmv_sigmoid_top.sv
// csr_spmv_sigmoid_top: CSR sparse matrix times vector with a logistic
// activation per row. Unpacks the stream words; uses spmv_ctrl, spmv_datapath.
`timescale 1ns / 1ps
//
// Usage
//   Input words arrive on s_tvalid/s_tready. s_tuser carries the action:
//   write a nonzero, write a row pointer, write a vector element, or run.
//   Load words give no output. A run word produces one output word per
//   row on m_tvalid/m_tready, with m_tlast on the final row. Rows per run
//   come from the row count register, written on cfg_valid/cfg_ready.
//   Write it only while the block is idle; the block does not enforce it.
// Timing
//   The nonzero store has one read port, so the walk reads one nonzero a
//   cycle; each row then drains the pipe and clamps the sum for the lookup.
//   Input is not taken while a run is in progress.
// Reset and stall
//   Reset clears the controller, the row count (to 1) and the output valid
//   flag; the stores hold no defined value until written.
//   When m_tready is low, the next row is computed but held until the
//   output register frees up.

module csr_spmv_sigmoid_top #(
    parameter int MAX_ROWS     = spmv_pkg::MAX_ROWS_DEF,
    parameter int VECTOR_DEPTH = spmv_pkg::VECTOR_DEPTH_DEF,
    parameter int MAX_NONZEROS = spmv_pkg::MAX_NONZEROS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] slot, [12:8] column_number, [28:13] weight_value,
    // [37:29] pointer_value, [53:38] element_value, [55:54] zero
    input  logic [spmv_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] action
    input  logic [spmv_pkg::ACTION_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [4:0] row_number, [20:5] activation, [23:21] zero
    output logic [spmv_pkg::M_TDATA_W-1:0]   m_tdata,
    // last_row
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [spmv_pkg::ROW_COUNT_W-1:0] cfg_data
);

    localparam int PA_W = $clog2(MAX_ROWS + 1);

    spmv_pkg::action_t   action;
    spmv_pkg::cmd_t      cmd;
    spmv_pkg::stat_t     stat;
    logic [PA_W-1:0]     ptr_addr;
    logic [spmv_pkg::ROW_W-1:0] out_row;
    logic                out_last;
    logic [spmv_pkg::ROW_W-1:0] row_number;
    logic [spmv_pkg::ACT_W-1:0] activation;

    assign action = spmv_pkg::action_t'(s_tuser);

    spmv_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_action  (action),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .ptr_addr  (ptr_addr),
        .out_row   (out_row),
        .out_last  (out_last),
        .stat      (stat)
    );

    spmv_datapath #(
        .MAX_ROWS     (MAX_ROWS),
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .MAX_NONZEROS (MAX_NONZEROS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .action        (action),
        .slot          (s_tdata[7:0]),
        .column_number (s_tdata[12:8]),
        .weight_value  ($signed(s_tdata[28:13])),
        .pointer_value (s_tdata[37:29]),
        .element_value ($signed(s_tdata[53:38])),
        .cmd           (cmd),
        .ptr_addr      (ptr_addr),
        .out_row       (out_row),
        .out_last      (out_last),
        .stat          (stat),
        .row_number    (row_number),
        .activation    (activation),
        .last_row      (m_tlast)
    );

    // Output word packing
    assign m_tdata = {3'b000, activation, row_number};

endmodule

>>> hw/rtl/spmv_checker.sv
// spmv_checker: port-level assertions for csr_spmv_sigmoid_top, bound in below.
// Depends on spmv_pkg and the top level's ports.
`timescale 1ns / 1ps

module spmv_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [spmv_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [spmv_pkg::ACTION_W-1:0]    s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [spmv_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tlast,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [spmv_pkg::ROW_COUNT_W-1:0] cfg_data
);

    logic [spmv_pkg::ROW_W-1:0] exp_row_reg, exp_row_next;
    logic                       out_take;

    assign out_take = m_tvalid && m_tready;

    // Expected row number of the next output word
    always_comb
    begin
        exp_row_next = exp_row_reg;
        if (out_take)
            exp_row_next = m_tlast ? '0 : (m_tdata[4:0] + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_row_reg <= '0;
        else
            exp_row_reg <= exp_row_next;
    end

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Rows come out in order, restarting after the last one
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (m_tdata[4:0] == exp_row_reg))
        else $error("row number out of sequence");

    // No input is taken while a run still has rows to give
    a_busy_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a run");

    // Padding bits of the output word stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:21] == 3'b000))
        else $error("output padding not zero");

endmodule

bind csr_spmv_sigmoid_top spmv_checker u_spmv_checker (.*);
